### rtl/core/socd_last_input_priority_core_assert.svh
// Assertion shorthands for the SOCD cleaner core.
// Each macro expects clk and arst_n in scope.
`ifndef SOCD_LAST_INPUT_PRIORITY_CORE_ASSERT_SVH
`define SOCD_LAST_INPUT_PRIORITY_CORE_ASSERT_SVH

// Same-cycle implication
`define SOCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SOCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/socd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package socd_pkg;

	localparam int KEY_W       = 8;
	localparam int GRP_W       = 3;
	localparam int SLOT_W      = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int SLOT_EN_BIT = 11;
	localparam int GRP_LSB     = 8;

	// One raw key event
	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             is_down;
		logic             injected;
		logic             bypass;
	} socd_item_t;

	// One emitted key event
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             down;
		logic             synthesized;
		logic             last;
	} socd_result_t;

endpackage

`default_nettype wire

### rtl/core/socd_slot_match.sv
`timescale 1ns / 1ps
`default_nettype none

module socd_slot_match import socd_pkg::*; #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_GROUPS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [SLOT_W-1:0]    wr_data,
	input  wire socd_item_t           item,
	output logic                      hit,
	output logic [NUM_SLOTS-1:0]      slot_oh,
	output logic [NUM_GROUPS-1:0]     group_oh
);

	logic [SLOT_W-1:0]    slot_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] match;

	// Store slot mapping registers; writes past the slot count drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) slot_q[s] <= '0;
		end else if (wr_en) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (wr_index == CFG_IDX_W'(s)) slot_q[s] <= wr_data;
			end
		end
	end

	// Compare every slot in parallel
	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			match[s] = slot_q[s][SLOT_EN_BIT]
				&& (slot_q[s][KEY_W-1:0] == item.key_code)
				&& (slot_q[s][KEY_W-1:0] != '0)
				&& (32'(slot_q[s][GRP_LSB +: GRP_W]) < NUM_GROUPS);
		end
	end

	// Keep the lowest matching slot, then decode its group
	always_comb begin
		slot_oh  = match & (~match + NUM_SLOTS'(1));
		hit      = (match != '0) && !item.injected && !item.bypass;
		group_oh = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				if (slot_oh[s] && (slot_q[s][GRP_LSB +: GRP_W] == GRP_W'(g)))
					group_oh[g] = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/socd_group_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module socd_group_ctrl import socd_pkg::*; #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_GROUPS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire socd_item_t        item,
	input  wire logic              hit,
	input  wire logic [NUM_SLOTS-1:0]  slot_oh,
	input  wire logic [NUM_GROUPS-1:0] group_oh,
	output socd_result_t [1:0]     res,
	output logic [1:0]             n_res
);

	logic [NUM_SLOTS-1:0] key_held_q;
	logic [KEY_W-1:0]     active_q   [NUM_GROUPS];
	logic [KEY_W-1:0]     previous_q [NUM_GROUPS];

	logic             held;
	logic [KEY_W-1:0] act;
	logic [KEY_W-1:0] prev;
	logic [KEY_W-1:0] prev_kept;
	logic             held_n;
	logic [KEY_W-1:0] act_n;
	logic [KEY_W-1:0] prev_n;

	// Read the selected slot and group
	always_comb begin
		held = |(key_held_q & slot_oh);
		act  = '0;
		prev = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (group_oh[g]) begin
				act  = act | active_q[g];
				prev = prev | previous_q[g];
			end
		end
	end

	// Resolve last-input priority for one event
	always_comb begin
		held_n    = held;
		act_n     = act;
		prev_kept = (prev == item.key_code && !held) ? '0 : prev;
		prev_n    = prev;
		res       = '0;
		n_res     = 2'd0;
		if (!hit) begin
			res[0] = '{key: item.key_code, down: item.is_down, synthesized: 1'b0, last: 1'b1};
			n_res  = 2'd1;
		end else if (item.is_down) begin
			if (!held) begin
				held_n = 1'b1;
				act_n  = item.key_code;
				res[0] = '{key: item.key_code, down: 1'b1, synthesized: 1'b1, last: 1'b1};
				n_res  = 2'd1;
				if (act != '0 && act != item.key_code) begin
					prev_n        = act;
					res[0].last   = 1'b0;
					res[1]        = '{key: act, down: 1'b0, synthesized: 1'b1, last: 1'b1};
					n_res         = 2'd2;
				end
			end
		end else begin
			prev_n = prev_kept;
			if (held) begin
				held_n = 1'b0;
				prev_n = '0;
				res[0] = '{key: item.key_code, down: 1'b0, synthesized: 1'b1, last: 1'b1};
				n_res  = 2'd1;
				if (act == item.key_code && prev_kept != '0) begin
					act_n       = prev_kept;
					res[0].last = 1'b0;
					res[1]      = '{key: prev_kept, down: 1'b1, synthesized: 1'b1, last: 1'b1};
					n_res       = 2'd2;
				end else if (act == item.key_code) begin
					act_n = '0;
				end
			end
		end
	end

	// Commit held flag and group keys on each processed event that hits a slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q <= '0;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				active_q[g]   <= '0;
				previous_q[g] <= '0;
			end
		end else if (fire && hit) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (slot_oh[s]) key_held_q[s] <= held_n;
			end
			for (int g = 0; g < NUM_GROUPS; g++) begin
				if (group_oh[g]) begin
					active_q[g]   <= act_n;
					previous_q[g] <= prev_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/socd_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module socd_out_queue import socd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_n,
	input  wire socd_result_t [1:0] push_res,
	output logic                    space,
	output logic                    dst_valid,
	input  wire logic               dst_stall,
	output socd_result_t            head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	socd_result_t     ent_q [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign dst_valid = (count_q != '0);
	assign head      = ent_q[rd_ptr_q];
	assign pop       = dst_valid && !dst_stall;
	assign space     = (count_q <= CNT_W'(DEPTH - 2));

	// Store up to two results per cycle
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) ent_q[wr_ptr_q] <= push_res[0];
		if (push_n == 2'd2) ent_q[wr_ptr_q + PTR_W'(1)] <= push_res[1];
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/socd_last_input_priority_core.sv
`timescale 1ns / 1ps
`default_nettype none

// SOCD cleaner, last-input priority. Each accepted key event is held in one
// input register, matched against all slot registers in parallel and
// resolved against its group's active and overridden key in the same cycle;
// the zero, one or two resulting events go into a four-entry output queue.
// A new event is taken every cycle as long as the queue has room for two
// results (at most two entries waiting), so the sustained rate is one
// event per cycle while the result side keeps up and each event gives at
// most one result; events that give two results are drained at one result
// per cycle while dst_stall is low. Slot registers may only be written
// while no event is in flight.
module socd_last_input_priority_core import socd_pkg::*; #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_GROUPS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [SLOT_W-1:0]    wr_data,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire logic [KEY_W-1:0]     key_code,
	input  wire logic                 is_down,
	input  wire logic                 injected,
	input  wire logic                 bypass,
	output logic                      dst_valid,
	input  wire logic                 dst_stall,
	output logic [KEY_W-1:0]          out_key,
	output logic                      out_down,
	output logic                      synthesized,
	output logic                      last
);

	logic                valid_s1;
	socd_item_t          item_s1;
	logic                space;
	logic                fire;
	logic                hit;
	logic [NUM_SLOTS-1:0]  slot_oh;
	logic [NUM_GROUPS-1:0] group_oh;
	socd_result_t [1:0]  res;
	logic [1:0]          n_res;
	logic [1:0]          push_n;
	socd_result_t        head;

	assign fire      = valid_s1 && space;
	assign src_stall = valid_s1 && !space;
	assign push_n    = fire ? n_res : 2'd0;

	// Hold the accepted event until it can be processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			item_s1 <= '{key_code: key_code, is_down: is_down,
				injected: injected, bypass: bypass};
	end

	socd_slot_match #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_GROUPS (NUM_GROUPS)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_s1),
		.hit      (hit),
		.slot_oh  (slot_oh),
		.group_oh (group_oh)
	);

	socd_group_ctrl #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_GROUPS (NUM_GROUPS)
	) u_group (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.hit      (hit),
		.slot_oh  (slot_oh),
		.group_oh (group_oh),
		.res      (res),
		.n_res    (n_res)
	);

	socd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_res  (res),
		.space     (space),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.head      (head)
	);

	assign out_key     = head.key;
	assign out_down    = head.down;
	assign synthesized = head.synthesized;
	assign last        = head.last;

`include "socd_last_input_priority_core_assert.svh"

	`SOCD_ASSERT_IMP(a_fwd_single, fire && !hit, n_res == 2'd1, "forwarded event must give one result")
	`SOCD_ASSERT_IMP(a_pair_opposite, fire && n_res == 2'd2, res[0].down != res[1].down, "result pair must be one press and one release")
	`SOCD_ASSERT_NXT(a_pair_queued, fire && n_res == 2'd2, dst_valid, "result pair not visible after transfer")
	`SOCD_ASSERT_IMP(a_fwd_last, dst_valid && !synthesized, last, "forwarded result must close its event")

endmodule

`default_nettype wire

### tb/tb_socd_last_input_priority_core.sv
`timescale 1ns / 1ps

module tb_socd_last_input_priority_core;
	import socd_pkg::*;

	localparam int SLOTS  = 8;
	localparam int GROUPS = 8;

	localparam logic [7:0] VK_A = 8'h41;
	localparam logic [7:0] VK_D = 8'h44;
	localparam logic [7:0] VK_W = 8'h57;
	localparam logic [7:0] VK_S = 8'h53;

	typedef logic [SLOT_W-1:0] slot_bank_t [SLOTS];

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [SLOT_W-1:0]    wr_data = '0;
	logic                 src_valid = 1'b0;
	logic                 src_stall;
	logic [KEY_W-1:0]     key_code = 8'h01;
	logic                 is_down = 1'b0;
	logic                 injected = 1'b0;
	logic                 bypass = 1'b0;
	logic                 dst_valid;
	logic                 dst_stall = 1'b0;
	logic [KEY_W-1:0]     out_key;
	logic                 out_down;
	logic                 synthesized;
	logic                 last;

	// cleaner state as predicted
	slot_bank_t   slot_cfg;
	logic         slot_held [SLOTS];
	logic [7:0]   grp_active [GROUPS];
	logic [7:0]   grp_overridden [GROUPS];
	socd_result_t pending_events [$];

	int error_count = 0;

	// sender burst control
	bit src_gaps_on = 1'b1;
	int burst_left = 0;

	// receiver stall control
	bit hold_request = 1'b0;
	int hold_left = 0;
	int seg_left = 0;
	int stall_pct = 0;

	socd_last_input_priority_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.key_code   (key_code),
		.is_down    (is_down),
		.injected   (injected),
		.bypass     (bypass),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_key    (out_key),
		.out_down   (out_down),
		.synthesized(synthesized),
		.last       (last)
	);

	always #2 clk = ~clk;

	// Bound the run in case the block hangs
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Lowest enabled slot whose key matches, or -1
	function automatic int lookup_slot(logic [7:0] k);
		logic [SLOT_W-1:0] v;
		if (k == 8'h00)
			return -1;
		for (int s = 0; s < SLOTS; s++) begin
			v = slot_cfg[s];
			if (!v[SLOT_EN_BIT])
				continue;
			if (v[KEY_W-1:0] != k)
				continue;
			if (int'(v[GRP_LSB +: GRP_W]) >= GROUPS)
				continue;
			return s;
		end
		return -1;
	endfunction

	// Resolve one key event against its group and queue the events it emits
	task automatic clean_event(logic [7:0] k, logic d, logic inj, logic byp);
		socd_result_t batch [$];
		int s;
		logic [GRP_W-1:0] g;
		s = (inj || byp) ? -1 : lookup_slot(k);
		if (s < 0) begin
			pending_events.insert(pending_events.size(),
				'{key: k, down: d, synthesized: 1'b0, last: 1'b1});
			return;
		end
		g = slot_cfg[s][GRP_LSB +: GRP_W];
		if (d) begin
			if (!slot_held[s]) begin
				slot_held[s] = 1'b1;
				batch.insert(batch.size(),
					'{key: k, down: 1'b1, synthesized: 1'b1, last: 1'b0});
				if (grp_active[g] == 8'h00 || grp_active[g] == k) begin
					grp_active[g] = k;
				end else begin
					grp_overridden[g] = grp_active[g];
					grp_active[g] = k;
					batch.insert(batch.size(), '{key: grp_overridden[g], down: 1'b0,
						synthesized: 1'b1, last: 1'b0});
				end
			end
		end else begin
			// forget an overridden key that is released while not tracked as held
			if (grp_overridden[g] == k && !slot_held[s])
				grp_overridden[g] = 8'h00;
			if (slot_held[s]) begin
				slot_held[s] = 1'b0;
				if (grp_active[g] == k && grp_overridden[g] != 8'h00) begin
					batch.insert(batch.size(),
						'{key: k, down: 1'b0, synthesized: 1'b1, last: 1'b0});
					grp_active[g] = grp_overridden[g];
					grp_overridden[g] = 8'h00;
					batch.insert(batch.size(), '{key: grp_active[g], down: 1'b1,
						synthesized: 1'b1, last: 1'b0});
				end else begin
					grp_overridden[g] = 8'h00;
					if (grp_active[g] == k)
						grp_active[g] = 8'h00;
					batch.insert(batch.size(),
						'{key: k, down: 1'b0, synthesized: 1'b1, last: 1'b0});
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			pending_events.insert(pending_events.size(), batch[i]);
	endtask

	// Offer one key event, hold it until the transfer, then maybe pause
	task automatic send_event(logic [7:0] k, logic d, logic inj, logic byp);
		int gap;
		src_valid <= 1'b1;
		key_code  <= k;
		is_down   <= d;
		injected  <= inj;
		bypass    <= byp;
		do
			@(posedge clk);
		while (src_stall);
		clean_event(k, d, inj, byp);
		@(negedge clk);
		if (src_gaps_on) begin
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
				src_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left--;
		end
	endtask

	// Drop valid and wait until every expected event has come out or the limit runs out
	task automatic drain(int limit);
		int waited;
		waited = 0;
		src_valid <= 1'b0;
		@(negedge clk);
		while (pending_events.size() != 0 && waited < limit) begin
			@(negedge clk);
			waited++;
		end
		// let an event that emits nothing leave the input register
		repeat (4) @(negedge clk);
	endtask

	// Write all slot registers while the block is idle
	task automatic load_slots(slot_bank_t bank);
		drain(20000);
		for (int s = 0; s < SLOTS; s++) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_IDX_W'(s);
			wr_data  <= bank[s];
			slot_cfg[s] = bank[s];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SLOT_W-1:0] slot_word(logic en, logic [2:0] g, logic [7:0] k);
		return {en, g, k};
	endfunction

	// Check each result transfer against the oldest expected event
	always @(posedge clk) begin
		socd_result_t exp_ev;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result: key %0h down %0b syn %0b last %0b",
					out_key, out_down, synthesized, last);
				error_count++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (out_key !== exp_ev.key) begin
					$error("out_key: expected %0h, got %0h", exp_ev.key, out_key);
					error_count++;
				end
				if (out_down !== exp_ev.down) begin
					$error("out_down: expected %0b, got %0b", exp_ev.down, out_down);
					error_count++;
				end
				if (synthesized !== exp_ev.synthesized) begin
					$error("synthesized: expected %0b, got %0b", exp_ev.synthesized,
						synthesized);
					error_count++;
				end
				if (last !== exp_ev.last) begin
					$error("last: expected %0b, got %0b", exp_ev.last, last);
					error_count++;
				end
			end
		end
	end

	// Stall the result side in segments of varying density, or hold off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = 120;
			hold_request = 1'b0;
		end
		if (seg_left <= 0) begin
			seg_left = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 75;
			endcase
		end
		seg_left--;
		if (hold_left > 0) begin
			hold_left--;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Reset configuration: everything is forwarded as is
	task automatic test_forwarding();
		send_event(8'h01, 1'b1, 1'b0, 1'b0);
		send_event(8'hFF, 1'b0, 1'b0, 1'b0);
		send_event(VK_A, 1'b1, 1'b1, 1'b0);
		send_event(8'h80, 1'b0, 1'b0, 1'b1);
		send_event(VK_A, 1'b1, 1'b1, 1'b1);
	endtask

	// An opposing pair and a group of three keys, with a duplicate, a zero key and a disabled slot
	task automatic test_cleaning();
		slot_bank_t bank;
		bank[0] = slot_word(1'b1, 3'd0, VK_A);
		bank[1] = slot_word(1'b1, 3'd0, VK_D);
		bank[2] = slot_word(1'b1, 3'd7, VK_W);
		bank[3] = slot_word(1'b1, 3'd7, VK_S);
		bank[4] = slot_word(1'b1, 3'd1, VK_A);
		bank[5] = slot_word(1'b1, 3'd2, 8'h00);
		bank[6] = slot_word(1'b0, 3'd2, 8'h20);
		bank[7] = slot_word(1'b1, 3'd7, 8'hFF);
		load_slots(bank);
		// override, repeated press, release of active with overridden still held
		send_event(VK_A, 1'b1, 1'b0, 1'b0);
		send_event(VK_D, 1'b1, 1'b0, 1'b0);
		send_event(VK_D, 1'b1, 1'b0, 1'b0);
		send_event(VK_D, 1'b0, 1'b0, 1'b0);
		send_event(VK_A, 1'b0, 1'b0, 1'b0);
		send_event(VK_A, 1'b0, 1'b0, 1'b0);
		// release of a held key that is not active
		send_event(VK_A, 1'b1, 1'b0, 1'b0);
		send_event(VK_D, 1'b1, 1'b0, 1'b0);
		send_event(VK_A, 1'b0, 1'b0, 1'b0);
		send_event(VK_D, 1'b0, 1'b0, 1'b0);
		// top group and the top key code
		send_event(8'hFF, 1'b1, 1'b0, 1'b0);
		send_event(VK_W, 1'b1, 1'b0, 1'b0);
		send_event(VK_S, 1'b1, 1'b0, 1'b0);
		send_event(8'hFF, 1'b0, 1'b0, 1'b0);
		send_event(VK_S, 1'b0, 1'b0, 1'b0);
		send_event(VK_W, 1'b0, 1'b0, 1'b0);
		// mapped keys forwarded when injected or bypassed, disabled slot forwarded
		send_event(VK_A, 1'b1, 1'b1, 1'b0);
		send_event(VK_D, 1'b0, 1'b0, 1'b1);
		send_event(8'h20, 1'b1, 1'b0, 1'b0);
	endtask

	// Remap a held, overridden key to another slot, then release it untracked
	task automatic test_remap_while_held();
		slot_bank_t bank;
		send_event(VK_A, 1'b1, 1'b0, 1'b0);
		send_event(VK_D, 1'b1, 1'b0, 1'b0);
		bank = slot_cfg;
		bank[0] = slot_word(1'b0, 3'd0, VK_A);
		bank[4] = slot_word(1'b1, 3'd0, VK_A);
		load_slots(bank);
		send_event(VK_A, 1'b0, 1'b0, 1'b0);
		send_event(VK_D, 1'b0, 1'b0, 1'b0);
		send_event(VK_A, 1'b1, 1'b0, 1'b0);
		send_event(VK_A, 1'b0, 1'b0, 1'b0);
	endtask

	// Hold off the result side while events keep coming, so the input stalls
	task automatic test_backpressure();
		slot_bank_t bank;
		logic [7:0] k;
		for (int s = 0; s < SLOTS; s++)
			bank[s] = slot_word(1'b1, 3'(s % 2), 8'h10 + 8'(s % 4));
		load_slots(bank);
		src_gaps_on = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++) begin
			k = 8'h10 + 8'($urandom_range(0, 3));
			send_event(k, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
		end
		src_gaps_on = 1'b1;
	endtask

	// Random slot maps, from all-ones and all-zero to dense opposing groups
	task automatic test_random_phases();
		slot_bank_t bank;
		logic [7:0] pool [6];
		logic [7:0] k;
		int r;
		for (int ph = 0; ph < 8; ph++) begin
			foreach (pool[i])
				pool[i] = (ph == 0) ? 8'hFF : 8'($urandom_range(1, 255));
			for (int s = 0; s < SLOTS; s++) begin
				if (ph == 0)
					bank[s] = '1;
				else if (ph == 1)
					bank[s] = '0;
				else
					bank[s] = slot_word($urandom_range(0, 9) != 0,
						3'($urandom_range(0, (ph % 2) ? 7 : 1)),
						($urandom_range(0, 9) == 0) ? 8'h00 : pool[$urandom_range(0, 5)]);
			end
			load_slots(bank);
			src_gaps_on = (ph % 3) != 2;
			for (int i = 0; i < 200; i++) begin
				r = $urandom_range(0, 99);
				k = pool[$urandom_range(0, 5)];
				if (r < 80)
					send_event(k, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
				else if (r < 88)
					send_event(k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					send_event(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
		src_gaps_on = 1'b1;
	endtask

	initial begin
		for (int s = 0; s < SLOTS; s++) begin
			slot_cfg[s] = '0;
			slot_held[s] = 1'b0;
		end
		for (int g = 0; g < GROUPS; g++) begin
			grp_active[g] = 8'h00;
			grp_overridden[g] = 8'h00;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_forwarding();
		test_cleaning();
		test_remap_while_held();
		test_backpressure();
		test_random_phases();

		drain(50000);
		repeat (10) @(negedge clk);
		if (pending_events.size() != 0) begin
			$error("%0d expected results never arrived", pending_events.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
